[rtl/nnp_pkg.sv]
package nnp_pkg;

	localparam int NODE_COUNT = 256;
	localparam int SLOT_W     = 8;
	// only slots reachable through the 8-bit slot field can ever hold a node
	localparam int SCAN_COUNT = (NODE_COUNT < (1 << SLOT_W)) ? NODE_COUNT : (1 << SLOT_W);
	localparam int ADDR_W     = (SCAN_COUNT > 1) ? $clog2(SCAN_COUNT) : 1;

	localparam int COORD_W = 20;
	localparam int MAG_W   = 20;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int PL_W    = SQ_W + 1;
	localparam int DIST_W  = 42;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} pos_t;

	typedef struct packed {
		logic              vld;
		logic              last;
		logic [ADDR_W-1:0] idx;
	} tag_t;

	typedef struct packed {
		logic              vld;
		logic              last;
		logic              pass;
		logic [ADDR_W-1:0] idx;
		pos_t              pos;
		logic [PL_W-1:0]   pl;
		logic [DIST_W-1:0] sp;
	} cand_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
		pos_t              pos;
		logic [DIST_W-1:0] pl;
		logic [DIST_W-1:0] sp;
	} res_t;

endpackage

[rtl/nnp_node_mem.sv]
module nnp_node_mem (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [nnp_pkg::ADDR_W-1:0] wr_addr,
	input  logic                       wr_present,
	input  nnp_pkg::pos_t              wr_pos,
	input  logic                       rd_en,
	input  logic [nnp_pkg::ADDR_W-1:0] rd_addr,
	output nnp_pkg::pos_t              rd_pos,
	output logic                       rd_valid
);

	nnp_pkg::pos_t                    mem_q [nnp_pkg::SCAN_COUNT];
	logic [nnp_pkg::SCAN_COUNT-1:0]   valid_q;
	nnp_pkg::pos_t                    rd_pos_q;
	logic                             rd_valid_q;

	// coordinates need no clearing: an entry without its valid bit is never used
	always_ff @(posedge clk) begin
		if (wr_en && wr_present) begin
			mem_q[wr_addr] <= wr_pos;
		end
		if (rd_en) begin
			rd_pos_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= wr_present;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_pos   = rd_pos_q;
	assign rd_valid = rd_valid_q;

endmodule

[rtl/nnp_dist_pipe.sv]
module nnp_dist_pipe (
	input  logic                       clk,
	input  logic                       arst_n,
	input  nnp_pkg::tag_t              tag_s1,
	input  nnp_pkg::pos_t              node_pos,
	input  logic                       node_valid,
	input  nnp_pkg::pos_t              query_pos,
	input  logic [nnp_pkg::SQ_W-1:0]   radius_sq,
	input  logic                       gate_off,
	output nnp_pkg::cand_t             cand
);

	function automatic logic [nnp_pkg::MAG_W-1:0] abs_diff(
		logic signed [nnp_pkg::COORD_W-1:0] a,
		logic signed [nnp_pkg::COORD_W-1:0] b
	);
		logic signed [nnp_pkg::COORD_W:0] d;
		d = (nnp_pkg::COORD_W+1)'(a) - (nnp_pkg::COORD_W+1)'(b);
		return d[nnp_pkg::COORD_W] ? nnp_pkg::MAG_W'(-d) : d[nnp_pkg::MAG_W-1:0];
	endfunction

	nnp_pkg::tag_t               tag_s2, tag_s3, tag_s4, tag_s5;
	nnp_pkg::pos_t               pos_s2, pos_s3, pos_s4, pos_s5;
	logic                        present_s2, present_s3;
	logic [nnp_pkg::MAG_W-1:0]   mx_s2, my_s2, mz_s2;
	logic [nnp_pkg::SQ_W-1:0]    sqx_s3, sqy_s3, sqz_s3, sqz_s4;
	logic [nnp_pkg::PL_W-1:0]    pl_s4, pl_s5;
	logic                        pass_s4, pass_s5;
	logic [nnp_pkg::DIST_W-1:0]  sp_s5;
	logic [nnp_pkg::PL_W-1:0]    pl_d;

	assign pl_d = nnp_pkg::PL_W'(sqx_s3) + nnp_pkg::PL_W'(sqy_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
		end else begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
		end
	end

	always_ff @(posedge clk) begin
		// s2: absolute differences
		pos_s2     <= node_pos;
		present_s2 <= node_valid;
		mx_s2      <= abs_diff(node_pos.x, query_pos.x);
		my_s2      <= abs_diff(node_pos.y, query_pos.y);
		mz_s2      <= abs_diff(node_pos.z, query_pos.z);
		// s3: squares
		pos_s3     <= pos_s2;
		present_s3 <= present_s2;
		sqx_s3     <= mx_s2 * mx_s2;
		sqy_s3     <= my_s2 * my_s2;
		sqz_s3     <= mz_s2 * mz_s2;
		// s4: planar sum and radius gate
		pos_s4     <= pos_s3;
		pl_s4      <= pl_d;
		sqz_s4     <= sqz_s3;
		pass_s4    <= present_s3 && (gate_off || (pl_d <= nnp_pkg::PL_W'(radius_sq)));
		// s5: spatial sum
		pos_s5     <= pos_s4;
		pl_s5      <= pl_s4;
		pass_s5    <= pass_s4;
		sp_s5      <= nnp_pkg::DIST_W'(pl_s4) + nnp_pkg::DIST_W'(sqz_s4);
	end

	always_comb begin
		cand.vld  = tag_s5.vld;
		cand.last = tag_s5.last;
		cand.idx  = tag_s5.idx;
		cand.pass = pass_s5;
		cand.pos  = pos_s5;
		cand.pl   = pl_s5;
		cand.sp   = sp_s5;
	end

endmodule

[rtl/nnp_best_sel.sv]
module nnp_best_sel (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  nnp_pkg::cand_t cand,
	output nnp_pkg::res_t  res,
	output logic           done
);

	logic                        found_q;
	logic [nnp_pkg::ADDR_W-1:0]  idx_q;
	nnp_pkg::pos_t               pos_q;
	logic [nnp_pkg::PL_W-1:0]    pl_q;
	logic [nnp_pkg::DIST_W-1:0]  sp_q;
	logic                        done_q;
	logic                        better;

	// scan runs upwards, so a strict win keeps the lowest index on a full tie
	assign better = cand.vld && cand.pass &&
		(!found_q || (cand.sp < sp_q) || ((cand.sp == sp_q) && (cand.pl < pl_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			idx_q   <= '0;
			pos_q   <= '0;
			pl_q    <= '0;
			sp_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cand.vld && cand.last;
			if (start) begin
				found_q <= 1'b0;
				idx_q   <= '0;
				pos_q   <= '0;
				pl_q    <= '0;
				sp_q    <= '0;
			end else if (better) begin
				found_q <= 1'b1;
				idx_q   <= cand.idx;
				pos_q   <= cand.pos;
				pl_q    <= cand.pl;
				sp_q    <= cand.sp;
			end
		end
	end

	always_comb begin
		res.found = found_q;
		res.slot  = nnp_pkg::SLOT_W'(idx_q);
		res.pos   = pos_q;
		res.pl    = nnp_pkg::DIST_W'(pl_q);
		res.sp    = sp_q;
	end

	assign done = done_q;

endmodule

[rtl/nearest_node_projection.sv]
// Write beats give no result; a query scans every writable table entry at one
// entry a cycle through the node memory read port. No beat is taken while a query
// runs: the next beat is taken in the cycle after the result enters the output
// register, so an unaccepted result holds the next back.
// Reset clears all valid bits at once (no clearing pass) and sets the radius to 0.
module nearest_node_projection (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [71:0]  s_tdata,  // node_slot[7:0], entry_present, pos_x, pos_y, pos_z, pad
	input  logic [0:0]   s_tuser,  // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [151:0] m_tdata,  // best_slot[7:0], best_x, best_y, best_z, planar_dist_sq, space_dist_sq
	output logic [0:0]   m_tuser,  // found
	input  logic         cfg_we,
	input  logic [19:0]  cfg_wdata
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t                      state_q;
	logic [nnp_pkg::ADDR_W-1:0]  scan_addr_q;
	nnp_pkg::tag_t               tag_s1;
	nnp_pkg::pos_t               query_pos_q;
	logic [19:0]                 gate_q;
	logic [nnp_pkg::SQ_W-1:0]    radius_sq_q;
	logic                        m_tvalid_q;
	nnp_pkg::res_t               out_q;

	logic                        s_acc;
	logic                        in_kind;
	logic [nnp_pkg::SLOT_W-1:0]  in_slot;
	logic                        in_present;
	nnp_pkg::pos_t               in_pos;
	logic                        slot_ok;
	logic                        wr_en;
	logic                        query_start;
	logic                        scan_last;
	logic                        rd_en;
	nnp_pkg::pos_t               rd_pos;
	logic                        rd_valid;
	nnp_pkg::cand_t              cand;
	nnp_pkg::res_t               res;
	logic                        sel_done;

	assign in_kind    = s_tuser[0];
	assign in_slot    = s_tdata[7:0];
	assign in_present = s_tdata[8];
	assign in_pos.x   = s_tdata[28:9];
	assign in_pos.y   = s_tdata[48:29];
	assign in_pos.z   = s_tdata[68:49];

	assign s_tready    = (state_q == ST_IDLE);
	assign s_acc       = s_tvalid && s_tready;
	assign slot_ok     = ({1'b0, in_slot} < 9'(nnp_pkg::SCAN_COUNT));
	assign wr_en       = s_acc && (in_kind == nnp_pkg::KIND_WRITE) && slot_ok;
	assign query_start = s_acc && (in_kind == nnp_pkg::KIND_QUERY);
	assign scan_last   = (scan_addr_q == nnp_pkg::ADDR_W'(nnp_pkg::SCAN_COUNT - 1));
	assign rd_en       = (state_q == ST_SCAN);

	nnp_node_mem u_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_addr    (in_slot[nnp_pkg::ADDR_W-1:0]),
		.wr_present (in_present),
		.wr_pos     (in_pos),
		.rd_en      (rd_en),
		.rd_addr    (scan_addr_q),
		.rd_pos     (rd_pos),
		.rd_valid   (rd_valid)
	);

	nnp_dist_pipe u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.tag_s1     (tag_s1),
		.node_pos   (rd_pos),
		.node_valid (rd_valid),
		.query_pos  (query_pos_q),
		.radius_sq  (radius_sq_q),
		.gate_off   (gate_q == '0),
		.cand       (cand)
	);

	nnp_best_sel u_sel (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (query_start),
		.cand   (cand),
		.res    (res),
		.done   (sel_done)
	);

	always_ff @(posedge clk) begin
		if (query_start) begin
			query_pos_q <= in_pos;
		end
		if (state_q == ST_FINISH && (!m_tvalid_q || m_tready)) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_addr_q <= '0;
			tag_s1      <= '0;
			gate_q      <= '0;
			radius_sq_q <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				gate_q <= cfg_wdata;
			end
			// settles long before the first distance reaches the gate
			radius_sq_q <= gate_q * gate_q;

			tag_s1.vld  <= rd_en;
			tag_s1.last <= scan_last;
			tag_s1.idx  <= scan_addr_q;

			// loaded from FINISH, otherwise held until the beat is taken
			m_tvalid_q <= (state_q == ST_FINISH && (!m_tvalid_q || m_tready)) ||
				(m_tvalid_q && !m_tready);

			unique case (state_q)
				ST_IDLE: begin
					scan_addr_q <= '0;
					if (query_start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					scan_addr_q <= scan_addr_q + 1'b1;
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (sel_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid         = m_tvalid_q;
	assign m_tuser[0]       = out_q.found;
	assign m_tdata[7:0]     = out_q.slot;
	assign m_tdata[27:8]    = out_q.pos.x;
	assign m_tdata[47:28]   = out_q.pos.y;
	assign m_tdata[67:48]   = out_q.pos.z;
	assign m_tdata[109:68]  = out_q.pl;
	assign m_tdata[151:110] = out_q.sp;

	// nothing may reach the selector while no query is running
	a_idle_no_cand: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !cand.vld)
		else $error("candidate seen while idle");

	// end of scan is only reported while waiting for the pipeline to empty
	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		sel_done |-> (state_q == ST_DRAIN))
		else $error("selector done outside drain");

	// a miss carries an all-zero payload
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
		else $error("miss with non-zero payload");

	// the scan reads the memory exactly while a query is being swept
	a_scan_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |=> tag_s1.vld)
		else $error("scan cycle without a memory read");

endmodule

[tb/nearest_node_projection_test.sv]
module nearest_node_projection_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic          kind;
		logic [7:0]    slot;
		logic          present;
		nnp_pkg::pos_t pos;
	} node_beat_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [71:0]  s_tdata = '0;   // node_slot[7:0], entry_present, pos_x, pos_y, pos_z, pad
	logic [0:0]   s_tuser = '0;   // kind
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [151:0] m_tdata;        // best_slot[7:0], best_x, best_y, best_z, planar, space
	logic [0:0]   m_tuser;        // found
	logic         cfg_we = 1'b0;
	logic [19:0]  cfg_wdata = '0;

	nearest_node_projection dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	node_beat_t     pending_beats[$];
	nnp_pkg::res_t  projections_due[$];
	nnp_pkg::pos_t  placed[$];

	// shadow of the node table and gate register
	nnp_pkg::pos_t  node_at[nnp_pkg::NODE_COUNT];
	bit             node_live[nnp_pkg::NODE_COUNT];
	logic [19:0]    gate_radius_model = '0;

	int  beats_queued = 0;
	int  beats_taken = 0;
	int  writes_taken = 0;
	int  queries_taken = 0;
	int  hits_seen = 0;
	int  radii_used = 0;
	int  mismatches = 0;
	bit  sender_gaps = 1'b1;
	bit  receiver_stalls = 1'b1;
	bit  long_hold_req = 1'b0;
	int  gap_left = 0;
	int  stall_left = 0;
	int  long_hold_left = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic longint unsigned sq_diff(input logic signed [19:0] a,
			input logic signed [19:0] b);
		longint d;
		d = longint'(a) - longint'(b);
		return longint'(d * d);
	endfunction

	function automatic logic [19:0] rand_coord(input int mode);
		if (mode < 3)
			return 20'($urandom);
		if (mode < 7)
			return 20'(int'($urandom_range(0, 4000)) - 2000);
		return 20'(int'($urandom_range(0, 8)) - 4);
	endfunction

	task automatic enqueue(input node_beat_t b);
		pending_beats.insert(pending_beats.size(), b);
		beats_queued++;
	endtask

	task automatic queue_write(input int slot, input bit present, input int x, input int y,
			input int z);
		node_beat_t b;
		b.kind = nnp_pkg::KIND_WRITE;
		b.slot = 8'(slot);
		b.present = present;
		b.pos.x = 20'(x);
		b.pos.y = 20'(y);
		b.pos.z = 20'(z);
		enqueue(b);
	endtask

	task automatic queue_query(input int x, input int y, input int z);
		node_beat_t b;
		b.kind = nnp_pkg::KIND_QUERY;
		// slot and present are don't-care on a query, so scramble them
		b.slot = 8'($urandom_range(0, 255));
		b.present = 1'($urandom);
		b.pos.x = 20'(x);
		b.pos.y = 20'(y);
		b.pos.z = 20'(z);
		enqueue(b);
	endtask

	task automatic run_random(input int n);
		node_beat_t b;
		nnp_pkg::pos_t p;
		int mode;
		for (int k = 0; k < n; k++) begin
			b.kind = ($urandom_range(0, 99) < 55) ? nnp_pkg::KIND_WRITE : nnp_pkg::KIND_QUERY;
			b.slot = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 15))
				: 8'($urandom_range(0, 255));
			b.present = ($urandom_range(0, 99) < 85);
			mode = $urandom_range(0, 9);
			if (b.kind == nnp_pkg::KIND_QUERY && placed.size() > 0
					&& $urandom_range(0, 1) == 1) begin
				// land near a stored node so small gates still see hits
				p = placed[$urandom_range(0, placed.size() - 1)];
				b.pos.x = p.x + 20'(int'($urandom_range(0, 4)) - 2);
				b.pos.y = p.y + 20'(int'($urandom_range(0, 4)) - 2);
				b.pos.z = p.z + 20'(int'($urandom_range(0, 4)) - 2);
			end else begin
				b.pos.x = rand_coord(mode);
				b.pos.y = rand_coord(mode);
				b.pos.z = rand_coord(mode);
			end
			if (b.kind == nnp_pkg::KIND_WRITE && b.present)
				placed.insert(placed.size(), b.pos);
			enqueue(b);
		end
	endtask

	task automatic quiesce(input int tail);
		while (pending_beats.size() != 0 || beats_taken != beats_queued
				|| projections_due.size() != 0)
			@(negedge clk);
		repeat (tail) @(negedge clk);
	endtask

	task automatic set_radius(input logic [19:0] r);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		radii_used++;
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// sender: gap is drawn per beat and spent after that beat is taken
	always @(posedge clk) begin : drive_beats
		node_beat_t b;
		if (arst_n) begin
			if (s_tvalid && !s_tready) begin
				// hold the beat on offer
			end else if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_beats.size() > 0) begin
				b = pending_beats.pop_front();
				s_tdata <= {3'b000, b.pos.z, b.pos.y, b.pos.x, b.present, b.slot};
				s_tuser <= b.kind;
				s_tvalid <= 1'b1;
				gap_left = sender_gaps ? $urandom_range(0, 6) : 0;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// watches both sides: updates the shadow table, predicts and checks projections, drives m_tready
	always @(posedge clk) begin : watch_beats
		logic signed [19:0] qx, qy, qz;
		longint unsigned pl, sp, r2, best_pl, best_sp;
		int best;
		bit hit;
		nnp_pkg::res_t due;
		if (arst_n) begin
			if (cfg_we)
				gate_radius_model = cfg_wdata;

			if (s_tvalid && s_tready) begin
				beats_taken++;
				qx = s_tdata[28:9];
				qy = s_tdata[48:29];
				qz = s_tdata[68:49];
				if (s_tuser[0] == nnp_pkg::KIND_WRITE) begin
					writes_taken++;
					if (int'(s_tdata[7:0]) < nnp_pkg::NODE_COUNT) begin
						node_live[s_tdata[7:0]] = s_tdata[8];
						node_at[s_tdata[7:0]] = s_tdata[8] ?
							nnp_pkg::pos_t'({qx, qy, qz}) : '0;
					end
				end else begin
					queries_taken++;
					hit = 1'b0;
					best = 0;
					best_pl = 0;
					best_sp = 0;
					r2 = longint'(gate_radius_model) * longint'(gate_radius_model);
					for (int i = 0; i < nnp_pkg::NODE_COUNT; i++) begin
						if (node_live[i]) begin
							pl = sq_diff(node_at[i].x, qx) + sq_diff(node_at[i].y, qy);
							if (gate_radius_model == 0 || pl <= r2) begin
								sp = pl + sq_diff(node_at[i].z, qz);
								if (!hit || sp < best_sp || (sp == best_sp && pl < best_pl)) begin
									hit = 1'b1;
									best = i;
									best_pl = pl;
									best_sp = sp;
								end
							end
						end
					end
					due = '0;
					if (hit) begin
						due.found = 1'b1;
						due.slot = best[7:0];
						due.pos = node_at[best];
						due.pl = best_pl[41:0];
						due.sp = best_sp[41:0];
					end
					projections_due.insert(projections_due.size(), due);
				end
			end

			if (m_tvalid && m_tready) begin
				if (projections_due.size() == 0) begin
					$error("result beat with no query outstanding");
					mismatches++;
				end else begin
					due = projections_due.pop_front();
					if (m_tuser[0])
						hits_seen++;
					check_field("found", due.found, m_tuser[0]);
					check_field("best_slot", due.slot, m_tdata[7:0]);
					check_field("best_x", due.pos.x, $signed(m_tdata[27:8]));
					check_field("best_y", due.pos.y, $signed(m_tdata[47:28]));
					check_field("best_z", due.pos.z, $signed(m_tdata[67:48]));
					check_field("planar_dist_sq", due.pl, m_tdata[109:68]);
					check_field("space_dist_sq", due.sp, m_tdata[151:110]);
				end
				stall_left = receiver_stalls ? $urandom_range(0, 6) : 0;
			end

			if (long_hold_req) begin
				long_hold_left = 2000;
				long_hold_req = 1'b0;
			end
			if (long_hold_left > 0) begin
				long_hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		for (int i = 0; i < nnp_pkg::NODE_COUNT; i++) begin
			node_live[i] = 1'b0;
			node_at[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_radius(20'd0);
		queue_query(0, 0, 0);                        // empty table
		queue_write(0, 1'b1, 3, 4, 0);
		queue_write(1, 1'b1, 0, 0, 5);
		queue_query(0, 0, 0);                        // equal 3D, planar breaks the tie
		queue_write(7, 1'b1, 0, 0, 5);
		queue_query(0, 0, 0);                        // full tie, lowest slot wins
		queue_write(255, 1'b1, -524288, -524288, -524288);
		queue_write(0, 1'b0, 3, 4, 0);               // removal, only the valid bit clears
		queue_write(1, 1'b0, 0, 0, 0);
		queue_write(7, 1'b0, -1, -1, -1);
		queue_query(524287, 524287, 524287);         // largest distances
		queue_query(-524288, -524288, -524288);      // zero distance
		queue_write(128, 1'b0, 524287, -524288, 1);  // removing a never-written slot
		queue_query(0, 0, 0);
		quiesce(nnp_pkg::NODE_COUNT + 16);

		set_radius(20'd5);
		queue_write(2, 1'b1, 3, 4, 100);             // planar exactly on the gate edge
		queue_write(3, 1'b1, 3, 5, 0);               // nearer in 3D but just outside
		queue_query(0, 0, 0);
		queue_query(1000, 1000, 0);                  // nothing inside the gate
		quiesce(nnp_pkg::NODE_COUNT + 16);

		set_radius(20'hFFFFF);
		run_random(150);
		quiesce(nnp_pkg::NODE_COUNT + 16);

		// back-to-back beats against a receiver that holds off for a long stretch
		set_radius(20'd1);
		sender_gaps = 1'b0;
		run_random(150);
		long_hold_req = 1'b1;
		quiesce(nnp_pkg::NODE_COUNT + 16);

		set_radius(20'($urandom_range(1500, 3000)));
		sender_gaps = 1'b1;
		receiver_stalls = 1'b0;
		run_random(75);
		quiesce(0);
		run_random(75);
		quiesce(nnp_pkg::NODE_COUNT + 16);

		set_radius(20'd0);
		receiver_stalls = 1'b1;
		run_random(150);
		quiesce(nnp_pkg::NODE_COUNT + 16);

		$display("Run covered %0d table writes and %0d nearest-node queries (%0d hits)",
			writes_taken, queries_taken, hits_seen);
		$display("over %0d gate radius settings, from no gate through 1 mm to the maximum.",
			radii_used);
		if (mismatches == 0)
			$display("** nearest_node_projection: PASSED **");
		else
			$display("** nearest_node_projection: FAILED **");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("** nearest_node_projection: FAILED **");
		$finish;
	end

endmodule
